### sv/rcfp_pkg.sv
// Shared types and constants for the RC link frame parser.
// Used by the unpacker, the top level and its port checker.
`timescale 1ns / 1ps

package rcfp_pkg;

    // Frame store geometry
    localparam int FRAME_BYTES = 64;
    localparam int ADDR_W      = $clog2(FRAME_BYTES);
    localparam int FILL_W      = ADDR_W + 1;

    // Frame format
    localparam logic [7:0] SYNC_A   = 8'hC8;
    localparam logic [7:0] SYNC_B   = 8'h00;
    localparam logic [7:0] LEN_MIN  = 8'd2;
    localparam logic [7:0] LEN_MAX  = 8'd62;
    localparam logic [7:0] CH_LEN   = 8'd24;
    localparam logic [7:0] CH_TYPE  = 8'h16;
    localparam logic [7:0] CRC_POLY = 8'hD5;

    // Channel unpacking
    localparam int CHANNELS = 16;
    localparam int CH_IDX_W = 4;
    localparam int CH_BITS  = 11;
    localparam int CH_FIRST = 3;
    localparam int ACC_W    = CH_BITS + 7;
    localparam int NB_W     = $clog2(ACC_W + 1);

    // Stream widths
    localparam int S_TDATA_W = 40;
    localparam int EV_W      = 3;

    typedef enum logic [EV_W-1:0] {
        EV_ABSORB   = 3'd0,
        EV_LEN_ERR  = 3'd1,
        EV_CRC_ERR  = 3'd2,
        EV_IGNORED  = 3'd3,
        EV_CHANNEL  = 3'd4
    } event_t;

    typedef enum logic [1:0] {
        UNP_IDLE,
        UNP_READ,
        UNP_DATA,
        UNP_EMIT
    } unp_state_t;

    // One unpacked channel offered to the output stage
    typedef struct packed {
        logic                valid;
        logic                last;
        logic [CH_IDX_W-1:0] index;
        logic [CH_BITS-1:0]  value;
    } chan_t;

    // Result payload, last field in the lowest bits
    typedef struct packed {
        logic                link_seen;
        logic [31:0]         last_good_time;
        logic [31:0]         good_frames;
        logic [31:0]         crc_errors;
        logic [31:0]         frame_errors;
        logic [CH_BITS-1:0]  channel_value;
        logic [CH_IDX_W-1:0] channel_index;
        event_t              event_res;
    } res_t;

    localparam int RES_W     = $bits(res_t);
    // Everything above the event kind travels on tdata
    localparam int M_TDATA_W = RES_W - EV_W;

endpackage

### sv/rcfp_ram.sv
// Simple dual-port synchronous RAM with registered read data.
// Generic; holds the frame store of the parser.
`timescale 1ns / 1ps

module rcfp_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

### sv/rcfp_unpack.sv
// Channel unpacker: reads the payload bytes of a channel frame from the
// frame store and shifts out 11-bit channels. Depends on rcfp_pkg.
`timescale 1ns / 1ps

module rcfp_unpack
    import rcfp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic              out_free,
    input  logic [7:0]        rd_data,
    output logic [ADDR_W-1:0] rd_addr,
    output chan_t             chan,
    output logic              busy
);

    unp_state_t          state_reg, state_next;
    logic [ADDR_W-1:0]   ptr_reg, ptr_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [NB_W-1:0]     nbits_reg, nbits_next;
    logic [CH_IDX_W-1:0] ch_reg, ch_next;
    logic [NB_W-1:0]     nbits_add;
    logic                ch_last;

    assign nbits_add = nbits_reg + NB_W'(8);
    assign ch_last   = (ch_reg == CH_IDX_W'(CHANNELS - 1));

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            UNP_IDLE: begin
                if (start) begin
                    state_next = UNP_READ;
                end
            end
            UNP_READ: begin
                state_next = UNP_DATA;
            end
            UNP_DATA: begin
                if (nbits_add >= NB_W'(CH_BITS)) begin
                    state_next = UNP_EMIT;
                end else begin
                    state_next = UNP_READ;
                end
            end
            UNP_EMIT: begin
                if (out_free) begin
                    state_next = ch_last ? UNP_IDLE : UNP_READ;
                end
            end
            default: begin
                state_next = UNP_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        rd_addr     = ptr_reg;
        busy        = (state_reg != UNP_IDLE);
        chan.valid  = (state_reg == UNP_EMIT);
        chan.last   = ch_last;
        chan.index  = ch_reg;
        chan.value  = acc_reg[CH_BITS-1:0];
    end

    // Bit accumulator: append one byte, drop one channel
    always_comb begin
        ptr_next   = ptr_reg;
        acc_next   = acc_reg;
        nbits_next = nbits_reg;
        ch_next    = ch_reg;
        if (state_reg == UNP_IDLE && start) begin
            ptr_next   = ADDR_W'(CH_FIRST);
            acc_next   = '0;
            nbits_next = '0;
            ch_next    = '0;
        end else if (state_reg == UNP_DATA) begin
            acc_next   = acc_reg | (ACC_W'(rd_data) << nbits_reg);
            nbits_next = nbits_add;
            ptr_next   = ptr_reg + ADDR_W'(1);
        end else if (state_reg == UNP_EMIT && out_free) begin
            acc_next   = acc_reg >> CH_BITS;
            nbits_next = nbits_reg - NB_W'(CH_BITS);
            ch_next    = ch_reg + CH_IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= UNP_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg   <= ptr_next;
        acc_reg   <= acc_next;
        nbits_reg <= nbits_next;
        ch_reg    <= ch_next;
    end

endmodule

### sv/rc_link_frame_parser_core.sv
// Top level of the RC link frame parser: byte framing, CRC check, counters,
// output register. Depends on rcfp_pkg, rcfp_ram and rcfp_unpack.
`timescale 1ns / 1ps

// Usage
//   s_ channel: one received byte per transfer with its millisecond timestamp.
//   m_ channel: results, with the kind of result on tuser. Every byte gives
//   one result with tlast set, except the final byte of a good channel
//   frame, which gives a run of sixteen channel results, tlast on the last.
//   A byte's result enters the output register the cycle after its transfer.
//   Throughput: one byte per cycle while hunting and gathering and the output
//   register is free. After a channel frame the unpacker reads 22 payload
//   bytes through the single read port of the frame store, with a read and a
//   data state per byte and an emit state per channel; s_tready stays low for
//   that run. The running CRC is updated as bytes arrive, so the CRC byte is
//   checked as it is accepted. Reset clears the counters, the seen flag and
//   the framing state; the store keeps its contents, since every byte read
//   back was written in the frame. When the receiver stalls, the result is
//   held in the output register and s_tready falls until the register drains.

module rc_link_frame_parser_core
    import rcfp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // rx_byte[7:0], time_ms[39:8]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // channel_index[3:0], channel_value[14:4], frame_errors[46:15],
    // crc_errors[78:47], good_frames[110:79], last_good_time[142:111],
    // link_seen[143]
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [EV_W-1:0]      m_tuser,   // event_res[2:0]
    output logic                 m_tlast
);

    logic [7:0]        rx_byte;
    logic [31:0]       time_ms;
    logic              s_fire;
    logic              out_free;

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] exp_reg, exp_next;
    logic [FILL_W-1:0] fill_inc;
    logic [7:0]        crc_reg, crc_next;
    logic [7:0]        type_reg, type_next;
    logic [31:0]       fe_reg, fe_next;
    logic [31:0]       ce_reg, ce_next;
    logic [31:0]       gf_reg, gf_next;
    logic [31:0]       gtime_reg, gtime_next;
    logic              seen_reg, seen_next;

    logic              byte_res;
    event_t            byte_ev;
    logic              unp_start;
    logic              len_bad;

    logic              mem_we;
    logic [7:0]        mem_rdata;
    logic [ADDR_W-1:0] mem_raddr;
    chan_t             chan;
    logic              unp_busy;

    res_t              res_reg, res_next;
    logic              last_reg, last_next;
    logic              mvalid_reg, mvalid_next;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    assign rx_byte  = s_tdata[7:0];
    assign time_ms  = s_tdata[39:8];
    assign out_free = !mvalid_reg || m_tready;
    assign s_tready = !unp_busy && out_free;
    assign s_fire   = s_tvalid && s_tready;
    assign fill_inc = fill_reg + FILL_W'(1);
    assign len_bad  = (rx_byte < LEN_MIN) || (rx_byte > LEN_MAX)
                   || ((9'(rx_byte) + 9'd2) > 9'(FRAME_BYTES));

    // Framing, CRC and counters for one accepted byte
    always_comb begin
        fill_next  = fill_reg;
        exp_next   = exp_reg;
        crc_next   = crc_reg;
        type_next  = type_reg;
        fe_next    = fe_reg;
        ce_next    = ce_reg;
        gf_next    = gf_reg;
        gtime_next = gtime_reg;
        seen_next  = seen_reg;
        mem_we     = 1'b0;
        byte_res   = 1'b0;
        byte_ev    = EV_ABSORB;
        unp_start  = 1'b0;
        if (s_fire) begin
            byte_res = 1'b1;
            if (fill_reg == '0) begin
                // hunt for sync
                if (rx_byte == SYNC_A || rx_byte == SYNC_B) begin
                    mem_we    = 1'b1;
                    fill_next = FILL_W'(1);
                end
            end else if (fill_reg == FILL_W'(1)) begin
                // length byte
                if (len_bad) begin
                    fe_next   = fe_reg + 32'd1;
                    fill_next = '0;
                    exp_next  = '0;
                    byte_ev   = EV_LEN_ERR;
                end else begin
                    mem_we    = 1'b1;
                    fill_next = FILL_W'(2);
                    exp_next  = FILL_W'(9'(rx_byte) + 9'd2);
                    crc_next  = '0;
                end
            end else if (fill_inc < exp_reg) begin
                // type and payload bytes: store and fold into the CRC
                mem_we    = 1'b1;
                fill_next = fill_inc;
                crc_next  = crc8_step(crc_reg, rx_byte);
                if (fill_reg == FILL_W'(2)) begin
                    type_next = rx_byte;
                end
            end else begin
                // CRC byte closes the frame
                mem_we    = 1'b1;
                fill_next = '0;
                exp_next  = '0;
                if (rx_byte != crc_reg) begin
                    ce_next = ce_reg + 32'd1;
                    byte_ev = EV_CRC_ERR;
                end else if (exp_reg != FILL_W'(9'(CH_LEN) + 9'd2) || type_reg != CH_TYPE) begin
                    byte_ev = EV_IGNORED;
                end else begin
                    gf_next    = gf_reg + 32'd1;
                    gtime_next = time_ms;
                    seen_next  = 1'b1;
                    byte_res   = 1'b0;
                    unp_start  = 1'b1;
                end
            end
        end
    end

    rcfp_ram #(
        .DEPTH (FRAME_BYTES),
        .WIDTH (8)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (fill_reg[ADDR_W-1:0]),
        .wdata (rx_byte),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Input is held off while unpacking, so reads never meet a pending write
    rcfp_unpack u_unpack (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (unp_start),
        .out_free (out_free),
        .rd_data  (mem_rdata),
        .rd_addr  (mem_raddr),
        .chan     (chan),
        .busy     (unp_busy)
    );

    // Output register: load a byte result or a channel, drain on transfer
    always_comb begin
        res_next                = res_reg;
        last_next               = last_reg;
        mvalid_next             = mvalid_reg && !m_tready;
        res_next.frame_errors   = fe_next;
        res_next.crc_errors     = ce_next;
        res_next.good_frames    = gf_next;
        res_next.last_good_time = gtime_next;
        res_next.link_seen      = seen_next;
        if (byte_res) begin
            mvalid_next            = 1'b1;
            last_next              = 1'b1;
            res_next.event_res     = byte_ev;
            res_next.channel_index = '0;
            res_next.channel_value = '0;
        end else if (chan.valid && out_free) begin
            mvalid_next            = 1'b1;
            last_next              = chan.last;
            res_next.event_res     = EV_CHANNEL;
            res_next.channel_index = chan.index;
            res_next.channel_value = chan.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg   <= '0;
            exp_reg    <= '0;
            fe_reg     <= '0;
            ce_reg     <= '0;
            gf_reg     <= '0;
            gtime_reg  <= '0;
            seen_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            fill_reg   <= fill_next;
            exp_reg    <= exp_next;
            fe_reg     <= fe_next;
            ce_reg     <= ce_next;
            gf_reg     <= gf_next;
            gtime_reg  <= gtime_next;
            seen_reg   <= seen_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        crc_reg  <= crc_next;
        type_reg <= type_next;
        res_reg  <= res_next;
        last_reg <= last_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = res_reg.event_res;
    assign m_tdata  = res_reg[RES_W-1:EV_W];

endmodule

### sv/rcfp_checker.sv
// Port-level checks for the RC link frame parser, bound to the top level.
// Depends on rcfp_pkg.
`timescale 1ns / 1ps

module rcfp_checker
    import rcfp_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [EV_W-1:0]      m_tuser,
    input logic                 m_tlast
);

    res_t res;
    assign res = res_t'({m_tdata, m_tuser});

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
        && $stable(m_tlast))
        else $error("stalled result changed");

    // Close a channel run exactly on the final channel
    a_run_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.event_res == EV_CHANNEL
        |-> m_tlast == (res.channel_index == CH_IDX_W'(CHANNELS - 1)))
        else $error("tlast misplaced in channel run");

    // Every non-channel result is a single transfer
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.event_res != EV_CHANNEL |-> m_tlast)
        else $error("non-channel result without tlast");

    // Accept no byte in the middle of a channel run
    a_no_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.event_res == EV_CHANNEL && !m_tlast |-> !s_tready)
        else $error("input taken during channel run");

    // Keep the seen flag once set
    a_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.link_seen |=> !m_tvalid || res.link_seen)
        else $error("link_seen cleared");

endmodule

bind rc_link_frame_parser_core rcfp_checker u_rcfp_checker (.*);

### tb/testbench.sv
// Self-checking testbench for rc_link_frame_parser_core: byte stream in, parse results out.
// Depends on rcfp_pkg and the core; a scoreboard class predicts every result from the
// bytes accepted on the s_ side and checks each m_ transfer against it in order.
`timescale 1ns / 1ps

module testbench
    import rcfp_pkg::*;
();

    localparam int RESET_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 100;

    // Result predictor and store of pending results
    class link_parse_model;
        typedef struct packed {
            logic last;
            res_t res;
        } parse_result_t;

        logic [7:0]        frame_bytes [FRAME_BYTES];
        logic [FILL_W-1:0] fill_cnt;
        logic [FILL_W-1:0] want_cnt;
        logic [31:0]       len_err_total;
        logic [31:0]       crc_err_total;
        logic [31:0]       chan_frame_total;
        logic [31:0]       chan_frame_time;
        logic              link_up;
        parse_result_t     pending_results [$];
        int unsigned       mismatches;

        function new();
            foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
            fill_cnt         = '0;
            want_cnt         = '0;
            len_err_total    = '0;
            crc_err_total    = '0;
            chan_frame_total = '0;
            chan_frame_time  = '0;
            link_up          = 1'b0;
            mismatches       = 0;
        endfunction

        // One CRC-8 update, polynomial 0xD5, MSB first
        static function logic [7:0] crc_step(logic [7:0] crc, logic [7:0] data);
            logic [7:0] acc;
            acc = crc ^ data;
            for (int b = 0; b < 8; b++) begin
                acc = acc[7] ? ((acc << 1) ^ CRC_POLY) : (acc << 1);
            end
            return acc;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void push_result(event_t ev, logic [CH_IDX_W-1:0] idx,
                                  logic [CH_BITS-1:0] val, logic last);
            parse_result_t r;
            r.last               = last;
            r.res.event_res      = ev;
            r.res.channel_index  = idx;
            r.res.channel_value  = val;
            r.res.frame_errors   = len_err_total;
            r.res.crc_errors     = crc_err_total;
            r.res.good_frames    = chan_frame_total;
            r.res.last_good_time = chan_frame_time;
            r.res.link_seen      = link_up;
            pending_results.push_back(r);
        endfunction

        // Advance the parser by one accepted byte and queue its results
        function void note_byte(logic [7:0] rx, logic [31:0] stamp);
            logic [7:0]  len;
            logic [7:0]  crc;
            logic [23:0] window;
            int          bitpos;
            int          at;

            // Hunt for a sync byte
            if (fill_cnt == 0) begin
                if (rx == SYNC_A || rx == SYNC_B) begin
                    frame_bytes[0] = rx;
                    fill_cnt = FILL_W'(1);
                end
                push_result(EV_ABSORB, '0, '0, 1'b1);
                return;
            end

            // Length byte: reject and resync when out of range
            if (fill_cnt == 1) begin
                if (rx < LEN_MIN || rx > LEN_MAX || int'(rx) + 2 > FRAME_BYTES) begin
                    len_err_total++;
                    fill_cnt = '0;
                    want_cnt = '0;
                    push_result(EV_LEN_ERR, '0, '0, 1'b1);
                    return;
                end
                frame_bytes[1] = rx;
                fill_cnt = FILL_W'(2);
                want_cnt = FILL_W'(int'(rx) + 2);
                push_result(EV_ABSORB, '0, '0, 1'b1);
                return;
            end

            // Gather the body
            frame_bytes[fill_cnt[ADDR_W-1:0]] = rx;
            fill_cnt = fill_cnt + FILL_W'(1);
            if (fill_cnt < want_cnt) begin
                push_result(EV_ABSORB, '0, '0, 1'b1);
                return;
            end

            // Frame complete: check CRC over type and payload
            len      = frame_bytes[1];
            fill_cnt = '0;
            want_cnt = '0;
            crc      = 8'h00;
            for (int k = 0; k < int'(len) - 1; k++) begin
                crc = crc_step(crc, frame_bytes[(2 + k) % FRAME_BYTES]);
            end
            if (crc != frame_bytes[(int'(len) + 1) % FRAME_BYTES]) begin
                crc_err_total++;
                push_result(EV_CRC_ERR, '0, '0, 1'b1);
                return;
            end
            if (len != CH_LEN || frame_bytes[2] != CH_TYPE) begin
                push_result(EV_IGNORED, '0, '0, 1'b1);
                return;
            end

            // Channel frame: unpack 11-bit little-endian channels
            chan_frame_time = stamp;
            link_up         = 1'b1;
            chan_frame_total++;
            for (int ch = 0; ch < CHANNELS; ch++) begin
                bitpos = ch * CH_BITS;
                at     = CH_FIRST + bitpos / 8;
                window = {frame_bytes[(at + 2) % FRAME_BYTES],
                          frame_bytes[(at + 1) % FRAME_BYTES],
                          frame_bytes[at % FRAME_BYTES]};
                push_result(EV_CHANNEL, CH_IDX_W'(ch),
                            CH_BITS'(window >> (bitpos % 8)), ch == CHANNELS - 1);
            end
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
            if (exp_v !== got_v) begin
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, exp_v, got_v);
                mismatches++;
            end
        endfunction

        // Check one output transfer against the oldest prediction
        function void check_result(res_t got, logic got_last);
            parse_result_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, event %0d index %0d value 0x%0h",
                         $time, got.event_res, got.channel_index, got.channel_value);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("event_res", want.res.event_res, got.event_res);
            compare_field("channel_index", want.res.channel_index, got.channel_index);
            compare_field("channel_value", want.res.channel_value, got.channel_value);
            compare_field("tlast", want.last, got_last);
            compare_field("frame_errors", want.res.frame_errors, got.frame_errors);
            compare_field("crc_errors", want.res.crc_errors, got.crc_errors);
            compare_field("good_frames", want.res.good_frames, got.good_frames);
            compare_field("last_good_time", want.res.last_good_time, got.last_good_time);
            compare_field("link_seen", want.res.link_seen, got.link_seen);
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [EV_W-1:0]      m_tuser;
    logic                 m_tlast;

    int              src_idle_pct  = 0;
    int              sink_idle_pct = 0;
    int              phase_bytes   = 0;
    link_parse_model tracker       = new();

    rc_link_frame_parser_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    // Receiver: stall at random
    always @(posedge aclk) begin
        m_tready <= (sink_idle_pct == 0) || ($urandom_range(99) >= sink_idle_pct);
    end

    // Check every result transfer
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tracker.check_result(res_t'({m_tdata, m_tuser}), m_tlast);
        end
    end

    // Hard stop on a hung run
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("[rc_link_frame_parser_core] ERROR");
        $finish;
    end

    // Timestamp: 0 random with occasional extremes, 1 all zero, 2 all ones
    function automatic logic [31:0] pick_stamp(int mode);
        int roll;
        roll = $urandom_range(9);
        if (mode == 1 || (mode == 0 && roll == 0)) return 32'h0000_0000;
        if (mode == 2 || (mode == 0 && roll == 1)) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // Offer one byte and hold it until the transfer completes
    task automatic send_byte(input logic [7:0] rx, input logic [31:0] stamp);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {stamp, rx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.note_byte(rx, stamp);
        phase_bytes++;
    endtask

    // Full frame: sync, length, type, payload, CRC (optionally corrupted)
    // fill_mode: 0 random payload, 1 all ones, 2 all zeros
    task automatic send_frame(input logic [7:0] len, input logic [7:0] kind,
                              input bit bad_crc, input int fill_mode, input int time_mode);
        logic [7:0] body [$];
        logic [7:0] crc;
        body.push_back(kind);
        for (int i = 2; i < int'(len); i++) begin
            body.push_back(fill_mode == 1 ? 8'hFF : fill_mode == 2 ? 8'h00 : 8'($urandom));
        end
        crc = 8'h00;
        foreach (body[i]) crc = link_parse_model::crc_step(crc, body[i]);
        if (bad_crc) crc ^= 8'($urandom_range(1, 255));
        send_byte($urandom_range(1) ? SYNC_A : SYNC_B, pick_stamp(time_mode));
        send_byte(len, pick_stamp(time_mode));
        foreach (body[i]) send_byte(body[i], pick_stamp(time_mode));
        send_byte(crc, pick_stamp(time_mode));
    endtask

    task automatic send_noise(input int count);
        logic [7:0] rx;
        repeat (count) begin
            do rx = 8'($urandom); while (rx == SYNC_A || rx == SYNC_B);
            send_byte(rx, pick_stamp(0));
        end
    endtask

    // Hold the sender off until every predicted result has been seen
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (tracker.pending() > 0) @(posedge aclk);
    endtask

    // Random mix of well-formed and broken frames
    task automatic run_phase(input int src_pct, input int sink_pct, input int budget);
        int         pick;
        logic [7:0] len;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        phase_bytes   = 0;
        while (phase_bytes < budget) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                send_frame(CH_LEN, CH_TYPE, 1'b0,
                           $urandom_range(9) == 0 ? $urandom_range(1, 2) : 0, 0);
            end else if (pick < 50) begin
                send_frame(CH_LEN, CH_TYPE, 1'b1, 0, 0);
            end else if (pick < 68) begin
                len = $urandom_range(4) == 0 ? 8'($urandom_range(13, LEN_MAX))
                                             : 8'($urandom_range(LEN_MIN, 12));
                send_frame(len, 8'($urandom), $urandom_range(3) == 0, 0, 0);
            end else if (pick < 75) begin
                // channel type with wrong length, or channel length with wrong type
                if ($urandom_range(1)) begin
                    do len = 8'($urandom_range(LEN_MIN, LEN_MAX)); while (len == CH_LEN);
                    send_frame(len, CH_TYPE, 1'b0, 0, 0);
                end else begin
                    send_frame(CH_LEN, CH_TYPE ^ 8'($urandom_range(1, 255)), 1'b0, 0, 0);
                end
            end else if (pick < 87) begin
                send_byte($urandom_range(1) ? SYNC_A : SYNC_B, pick_stamp(0));
                send_byte($urandom_range(1) ? 8'($urandom_range(0, 1))
                                            : 8'($urandom_range(63, 255)), pick_stamp(0));
            end else begin
                send_noise($urandom_range(1, 4));
            end
        end
        hold_until_drained();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: noise while hunting, length errors at both syncs, short frames
        src_idle_pct  = 35;
        sink_idle_pct = 87;
        send_byte(8'h55, pick_stamp(1));
        send_byte(8'hFF, pick_stamp(2));
        send_byte(8'h01, pick_stamp(0));
        send_byte(SYNC_A, pick_stamp(0));
        send_byte(8'd0, pick_stamp(0));
        send_byte(SYNC_B, pick_stamp(0));
        send_byte(8'd1, pick_stamp(0));
        send_byte(SYNC_A, pick_stamp(0));
        send_byte(LEN_MAX + 8'd1, pick_stamp(0));
        send_byte(SYNC_B, pick_stamp(0));
        send_byte(8'hFF, pick_stamp(0));
        send_frame(LEN_MIN, CH_TYPE, 1'b0, 0, 0);
        send_frame(LEN_MIN, 8'hA5, 1'b1, 0, 0);

        // Channel payload extremes with extreme timestamps, then a frame of maximum length
        send_frame(CH_LEN, CH_TYPE, 1'b0, 1, 2);
        send_frame(CH_LEN, CH_TYPE, 1'b0, 2, 1);
        send_frame(LEN_MAX, 8'($urandom), 1'b0, 0, 0);
        hold_until_drained();

        run_phase(35, 87, 50);
        run_phase(87, 35, 50);
        run_phase(0, 0, 40);

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("[rc_link_frame_parser_core] OK");
        end else begin
            $display("[rc_link_frame_parser_core] ERROR");
        end
        $finish;
    end

endmodule

### files.f
sv/rcfp_pkg.sv
sv/rcfp_ram.sv
sv/rcfp_unpack.sv
sv/rc_link_frame_parser_core.sv
sv/rcfp_checker.sv
tb/testbench.sv
